### sv/php_pkg.sv
// Package for the PES header parser: phase codes, result item type, field decode helpers.
package php_pkg;

	typedef enum logic [4:0] {
		PH_HUNT     = 5'd0,
		PH_PREFIX   = 5'd1,
		PH_SID      = 5'd2,
		PH_LEN      = 5'd3,
		PH_FLAGS    = 5'd4,
		PH_HDL      = 5'd5,
		PH_TS1      = 5'd6,
		PH_TS2      = 5'd7,
		PH_ESCR     = 5'd8,
		PH_RATE     = 5'd9,
		PH_TRICK    = 5'd10,
		PH_COPY     = 5'd11,
		PH_CRC      = 5'd12,
		PH_EXT      = 5'd13,
		PH_PRIV     = 5'd14,
		PH_PACKLEN  = 5'd15,
		PH_PACKSKIP = 5'd16,
		PH_SEQ      = 5'd17,
		PH_STD      = 5'd18,
		PH_X2LEN    = 5'd19,
		PH_X2SKIP   = 5'd20,
		PH_STUFF    = 5'd21,
		PH_SUB      = 5'd22,
		PH_PAYLOAD  = 5'd23,
		PH_M1PRE    = 5'd24,
		PH_M1POST   = 5'd25,
		PH_M1STD    = 5'd26,
		PH_M1TS1    = 5'd27,
		PH_M1TS2    = 5'd28
	} phase_t;

	localparam logic [3:0] KIND_SID     = 4'd0;
	localparam logic [3:0] KIND_LEN     = 4'd1;
	localparam logic [3:0] KIND_FLAGS   = 4'd2;
	localparam logic [3:0] KIND_PTS     = 4'd3;
	localparam logic [3:0] KIND_DTS     = 4'd4;
	localparam logic [3:0] KIND_ESCR    = 4'd5;
	localparam logic [3:0] KIND_RATE    = 4'd6;
	localparam logic [3:0] KIND_TRICK   = 4'd7;
	localparam logic [3:0] KIND_COPY    = 4'd8;
	localparam logic [3:0] KIND_CRC     = 4'd9;
	localparam logic [3:0] KIND_PRIV    = 4'd10;
	localparam logic [3:0] KIND_SEQ     = 4'd11;
	localparam logic [3:0] KIND_STD     = 4'd12;
	localparam logic [3:0] KIND_SUB     = 4'd13;
	localparam logic [3:0] KIND_PAYLOAD = 4'd14;
	localparam logic [3:0] KIND_STATUS  = 4'd15;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_START    = 3'd1;
	localparam logic [2:0] ERR_TOO_LONG = 3'd2;
	localparam logic [2:0] ERR_MARKER   = 3'd3;
	localparam logic [2:0] ERR_PTS_PFX  = 3'd4;
	localparam logic [2:0] ERR_DTS_PFX  = 3'd5;
	localparam logic [2:0] ERR_STD_PFX  = 3'd6;
	localparam logic [2:0] ERR_NEG_PAY  = 3'd7;

	localparam logic CFG_MODE    = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	localparam logic [7:0] SID_PRIV1 = 8'hBD;
	localparam logic [7:0] SID_PRIV2 = 8'hBF;
	localparam logic [7:0] M1_SKIP_BYTE = 8'h0F;

	typedef struct packed {
		logic [3:0]  kind;
		logic [32:0] value;
		logic [8:0]  extra;
		logic [2:0]  err;
		logic        last;
	} res_t;

	function automatic res_t mk_res(logic [3:0] kind, logic [32:0] value, logic [8:0] extra,
			logic [2:0] err);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.extra = extra;
		r.err   = err;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic logic [32:0] stamp(logic [47:0] w);
		return {w[35:33], w[31:17], w[15:1]};
	endfunction

	function automatic logic special_stream(logic [7:0] id);
		return id == 8'hBC || id == 8'hBE || id == 8'hBF || id == 8'hF0 ||
			id == 8'hF1 || id == 8'hF2 || id == 8'hF8 || id == 8'hFF;
	endfunction

	function automatic logic wanted(logic [4:0] p, logic [15:0] flags, logic [7:0] skip,
			logic [15:0] used, logic [7:0] hlen, logic [7:0] sid);
		logic w;
		unique case (p)
			PH_TS1:      w = flags[7];
			PH_TS2:      w = flags[7:6] == 2'b11;
			PH_ESCR:     w = flags[5];
			PH_RATE:     w = flags[4];
			PH_TRICK:    w = flags[3];
			PH_COPY:     w = flags[2];
			PH_CRC:      w = flags[1];
			PH_EXT:      w = flags[0];
			PH_PRIV:     w = flags[15];
			PH_PACKLEN:  w = flags[14];
			PH_PACKSKIP: w = flags[14] && skip != 8'd0;
			PH_SEQ:      w = flags[13];
			PH_STD:      w = flags[12];
			PH_X2LEN:    w = flags[8];
			PH_X2SKIP:   w = flags[8] && skip != 8'd0;
			PH_STUFF:    w = used < {8'd0, hlen};
			PH_SUB:      w = sid == SID_PRIV1;
			default:     w = 1'b1;
		endcase
		return w;
	endfunction

	function automatic phase_t adv_phase(phase_t cur, logic [15:0] flags, logic [7:0] skip,
			logic [15:0] used, logic [7:0] hlen, logic [7:0] sid);
		phase_t r;
		logic   found;
		r = PH_PAYLOAD;
		found = 1'b0;
		for (int i = PH_TS1; i <= PH_SUB; i++) begin
			if (!found && 5'(i) > cur && wanted(5'(i), flags, skip, used, hlen, sid)) begin
				r = phase_t'(5'(i));
				found = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### sv/pes_header_parser.sv
// PES header parser top level: byte-wise parse state and a two-entry result queue.
// A byte's result item is written into the result queue when the byte is accepted.
// Throughput: one byte per cycle while in_stall is low; each byte yields at most one result item.
// The parse state updates in the accepting cycle; a two-entry queue holds results.
// Reset: parser hunts for a start code, all state zero, mode MPEG-2, limit 65535.
module pes_header_parser import php_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  field_kind,
	output logic [32:0] field_value,
	output logic [8:0]  field_extra,
	output logic [2:0]  error_code,
	output logic        last_of_packet
);

	phase_t      phase_q, nphase;
	logic [23:0] ss_q, nss;
	logic [39:0] acc_q, nacc;
	logic [4:0]  bif_q, nbif;
	logic [7:0]  sid_q, nsid;
	logic [7:0]  hlen_q, nhlen;
	logic [15:0] used_q, nused;
	logic [15:0] flag_q, nflag;
	logic [7:0]  skip_q, nskip;
	logic [15:0] prem_q, nprem;
	logic        mode_q;
	logic [15:0] max_len_q;

	res_t        fifo_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	logic        has_res, fail_c, do_adv, in_acc, out_acc;
	logic [2:0]  fail_code;
	res_t        res;
	logic [47:0] w;
	logic [4:0]  n;
	logic [7:0]  b;
	logic [1:0]  pd;

	assign b = data_byte;
	assign pd = flag_q[7:6];
	assign in_stall = cnt_q == 2'd2;
	assign in_acc = in_valid && !in_stall;
	assign out_valid = cnt_q != 2'd0;
	assign out_acc = out_valid && !out_stall;

	always_comb begin
		nphase = phase_q;
		nss = ss_q;
		nacc = acc_q;
		nbif = bif_q;
		nsid = sid_q;
		nhlen = hlen_q;
		nused = used_q;
		nflag = flag_q;
		nskip = skip_q;
		nprem = prem_q;
		has_res = 1'b0;
		res = mk_res(KIND_STATUS, 33'd0, 9'd0, ERR_NONE);
		fail_c = 1'b0;
		fail_code = ERR_NONE;
		do_adv = 1'b0;
		w = 48'd0;

		if (phase_q >= PH_FLAGS && prem_q != 16'd0)
			nprem = prem_q - 16'd1;
		if (phase_q >= PH_TS1 && phase_q <= PH_X2SKIP && used_q != 16'hFFFF)
			nused = used_q + 16'd1;
		if (phase_q >= PH_LEN) begin
			w = {acc_q, b};
			nacc = w[39:0];
			nbif = bif_q + 5'd1;
		end
		n = nbif;

		unique case (phase_q)
			PH_HUNT: begin
				nss = {ss_q[15:0], b};
				if (bif_q < 5'd3)
					nbif = bif_q + 5'd1;
				if (nbif >= 5'd3 && nss == 24'd1) begin
					nphase = PH_SID;
					nbif = 5'd0;
				end
			end
			PH_PREFIX: begin
				if (b != ((bif_q == 5'd2) ? 8'd1 : 8'd0)) begin
					fail_c = 1'b1;
					fail_code = ERR_START;
				end else if (bif_q >= 5'd2) begin
					nphase = PH_SID;
					nbif = 5'd0;
				end else begin
					nbif = bif_q + 5'd1;
				end
			end
			PH_SID: begin
				nsid = b;
				has_res = 1'b1;
				res = mk_res(KIND_SID, {25'd0, b}, 9'd0, ERR_NONE);
				nflag = 16'd0;
				nhlen = 8'd0;
				nused = 16'd0;
				nskip = 8'd0;
				nphase = PH_LEN;
				nbif = 5'd0;
				nacc = 40'd0;
			end
			PH_LEN: begin
				if (n == 5'd2) begin
					has_res = 1'b1;
					res = mk_res(KIND_LEN, {17'd0, w[15:0]}, 9'd0, ERR_NONE);
					if (w[15:0] > max_len_q) begin
						fail_c = 1'b1;
						fail_code = ERR_TOO_LONG;
					end else begin
						nprem = w[15:0];
						nbif = 5'd0;
						nacc = 40'd0;
						if (mode_q)
							nphase = special_stream(sid_q) ? PH_PAYLOAD : PH_FLAGS;
						else
							nphase = (sid_q == SID_PRIV2) ? PH_PAYLOAD : PH_M1PRE;
					end
				end
			end
			PH_FLAGS: begin
				if (n == 5'd1) begin
					if (b[7:6] != 2'b10) begin
						fail_c = 1'b1;
						fail_code = ERR_MARKER;
					end
				end else begin
					has_res = 1'b1;
					res = mk_res(KIND_FLAGS, {17'd0, w[15:0]}, 9'd0, ERR_NONE);
					nflag = {8'd0, b};
					nphase = PH_HDL;
					nbif = 5'd0;
				end
			end
			PH_HDL: begin
				nhlen = b;
				nused = 16'd0;
				do_adv = 1'b1;
			end
			PH_TS1: begin
				if (n == 5'd1 && b[7:4] != {2'b00, pd}) begin
					fail_c = 1'b1;
					fail_code = ERR_PTS_PFX;
				end else if (n == 5'd5) begin
					has_res = 1'b1;
					res = mk_res(KIND_PTS, stamp(w), 9'd0, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_TS2: begin
				if (n == 5'd1 && b[7:4] != 4'd1) begin
					fail_c = 1'b1;
					fail_code = ERR_DTS_PFX;
				end else if (n == 5'd5) begin
					has_res = 1'b1;
					res = mk_res(KIND_DTS, stamp(w), 9'd0, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_ESCR: begin
				if (n == 5'd6) begin
					has_res = 1'b1;
					res = mk_res(KIND_ESCR, {w[45:43], w[41:27], w[25:11]}, w[9:1], ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_RATE: begin
				if (n == 5'd3) begin
					has_res = 1'b1;
					res = mk_res(KIND_RATE, {11'd0, w[22:1]}, 9'd0, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_TRICK: begin
				has_res = 1'b1;
				res = mk_res(KIND_TRICK, {28'd0, b[4:0]}, {6'd0, b[7:5]}, ERR_NONE);
				do_adv = 1'b1;
			end
			PH_COPY: begin
				has_res = 1'b1;
				res = mk_res(KIND_COPY, {26'd0, b[6:0]}, 9'd0, ERR_NONE);
				do_adv = 1'b1;
			end
			PH_CRC: begin
				if (n == 5'd2) begin
					has_res = 1'b1;
					res = mk_res(KIND_CRC, {17'd0, w[15:0]}, 9'd0, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_EXT: begin
				nflag = {b, flag_q[7:0]};
				do_adv = 1'b1;
			end
			PH_PRIV: begin
				has_res = 1'b1;
				res = mk_res(KIND_PRIV, {25'd0, b}, 9'd0, ERR_NONE);
				if (n >= 5'd16)
					do_adv = 1'b1;
			end
			PH_PACKLEN: begin
				nskip = b;
				do_adv = 1'b1;
			end
			PH_SEQ: begin
				if (n == 5'd2) begin
					has_res = 1'b1;
					res = mk_res(KIND_SEQ, {26'd0, w[14:8]}, {2'd0, b[6:0]}, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_STD: begin
				if (n == 5'd1 && b[7:6] != 2'b01) begin
					fail_c = 1'b1;
					fail_code = ERR_STD_PFX;
				end else if (n == 5'd2) begin
					has_res = 1'b1;
					res = mk_res(KIND_STD, {20'd0, w[12:0]}, {8'd0, w[13]}, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_X2LEN: begin
				nskip = {1'b0, b[6:0]};
				do_adv = 1'b1;
			end
			PH_PACKSKIP, PH_X2SKIP, PH_STUFF: begin
				if (skip_q != 8'd0)
					nskip = skip_q - 8'd1;
				if (nskip == 8'd0)
					do_adv = 1'b1;
			end
			PH_SUB: begin
				if (n == 5'd4) begin
					has_res = 1'b1;
					res = mk_res(KIND_SUB, {1'b0, w[31:0]}, 9'd0, ERR_NONE);
					do_adv = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				has_res = 1'b1;
				res = mk_res(KIND_PAYLOAD, {25'd0, b}, 9'd0, ERR_NONE);
			end
			PH_M1PRE, PH_M1POST: begin
				nacc = {32'd0, b};
				nbif = 5'd1;
				if (phase_q == PH_M1PRE && b[7]) begin
					// stuffing byte
				end else if (phase_q == PH_M1PRE && b[7:6] == 2'b01) begin
					nphase = PH_M1STD;
				end else if (b[7:4] == 4'd2 || b[7:4] == 4'd3) begin
					nflag = {8'd0, b[5:4], 6'd0};
					nphase = PH_M1TS1;
				end else if (b == M1_SKIP_BYTE) begin
					nphase = PH_PAYLOAD;
				end else begin
					has_res = 1'b1;
					res = mk_res(KIND_PAYLOAD, {25'd0, b}, 9'd0, ERR_NONE);
					nphase = PH_PAYLOAD;
				end
			end
			PH_M1STD: begin
				if (n == 5'd2) begin
					has_res = 1'b1;
					res = mk_res(KIND_STD, {20'd0, w[12:0]}, {8'd0, w[13]}, ERR_NONE);
					nphase = PH_M1POST;
					nbif = 5'd0;
				end
			end
			PH_M1TS1: begin
				if (n == 5'd5) begin
					has_res = 1'b1;
					res = mk_res(KIND_PTS, stamp(w), 9'd0, ERR_NONE);
					nphase = (pd == 2'b11) ? PH_M1TS2 : PH_PAYLOAD;
					nbif = 5'd0;
					nacc = 40'd0;
				end
			end
			PH_M1TS2: begin
				if (n == 5'd1 && b[7:4] != 4'd1) begin
					fail_c = 1'b1;
					fail_code = ERR_DTS_PFX;
				end else if (n == 5'd5) begin
					has_res = 1'b1;
					res = mk_res(KIND_DTS, stamp(w), 9'd0, ERR_NONE);
					nphase = PH_PAYLOAD;
					nbif = 5'd0;
				end
			end
			default: begin
				nphase = PH_HUNT;
				nbif = 5'd0;
				nss = 24'd0;
			end
		endcase

		if (!fail_c && do_adv) begin
			nphase = adv_phase(phase_q, nflag, nskip, nused, nhlen, nsid);
			nbif = 5'd0;
			nacc = 40'd0;
			if (nphase == PH_STUFF)
				nskip = nhlen - nused[7:0];
		end

		if (!fail_c && nphase >= PH_FLAGS && nphase <= PH_M1TS2 && nprem == 16'd0) begin
			if (nphase == PH_PAYLOAD || nphase == PH_M1PRE || nphase == PH_M1POST) begin
				if (!has_res)
					res = mk_res(KIND_STATUS, 33'd0, 9'd0, ERR_NONE);
				has_res = 1'b1;
				res.last = 1'b1;
				nphase = PH_PREFIX;
				nbif = 5'd0;
				nacc = 40'd0;
			end else begin
				fail_c = 1'b1;
				fail_code = ERR_NEG_PAY;
			end
		end

		if (fail_c) begin
			has_res = 1'b1;
			res = mk_res(KIND_STATUS, 33'd0, 9'd0, fail_code);
			res.last = 1'b1;
			nphase = PH_HUNT;
			nacc = 40'd0;
			if (phase_q == PH_PREFIX) begin
				nss = {16'd0, b};
				nbif = 5'd1;
			end else begin
				nss = 24'd0;
				nbif = 5'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			ss_q <= '0;
			acc_q <= '0;
			bif_q <= '0;
			sid_q <= '0;
			hlen_q <= '0;
			used_q <= '0;
			flag_q <= '0;
			skip_q <= '0;
			prem_q <= '0;
			mode_q <= 1'b1;
			max_len_q <= 16'hFFFF;
		end else begin
			if (in_acc) begin
				phase_q <= nphase;
				ss_q <= nss;
				acc_q <= nacc;
				bif_q <= nbif;
				sid_q <= nsid;
				hlen_q <= nhlen;
				used_q <= nused;
				flag_q <= nflag;
				skip_q <= nskip;
				prem_q <= nprem;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:    mode_q <= cfg_data[0];
					CFG_MAX_LEN: max_len_q <= cfg_data;
					default:     ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_acc && has_res)
				wp_q <= ~wp_q;
			if (out_acc)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_acc && has_res} - {1'b0, out_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res)
			fifo_q[wp_q] <= res;
	end

	assign field_kind = fifo_q[rp_q].kind;
	assign field_value = fifo_q[rp_q].value;
	assign field_extra = fifo_q[rp_q].extra;
	assign error_code = fifo_q[rp_q].err;
	assign last_of_packet = fifo_q[rp_q].last;

endmodule
